// File: rtl/matrix3_inverse_macros.svh
// Assertion helpers for the 3x3 inverse block.
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define M3I_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("m3i check failed");

// expression never true
`define M3I_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("m3i check failed");

`endif

// File: rtl/m3i_pkg.sv
`timescale 1ns / 1ps
package m3i_pkg;
	localparam int EW = 32;
	localparam int PW = 64;
	localparam int DW = 97;
	localparam int QW = 33;
	localparam int NE = 9;
	localparam int NP = 18;

	// operand indexes of the cofactor products, adj[j] = p[2j] - p[2j+1]
	localparam int PX [NP] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
	localparam int PY [NP] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

	localparam logic [QW-1:0] QPOS_MAX = 33'h07FFFFFFF;
	localparam logic [QW-1:0] QNEG_MAX = 33'h080000000;

	typedef struct packed {
		logic                     vld;
		logic                     sing;
		logic [DW-1:0]            d;
		logic [NE-1:0][DW-1:0]    r;
		logic [NE-1:0][QW-1:0]    q;
		logic [NE-1:0]            nb;
		logic [NE-1:0]            neg;
		logic [NE-1:0]            ovf;
	} div_t;
endpackage

// File: rtl/m3i_front.sv
`timescale 1ns / 1ps
module m3i_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   vld,
	input  logic [m3i_pkg::NE-1:0][m3i_pkg::EW-1:0] m,
	output m3i_pkg::div_t                          dout
);
	import m3i_pkg::*;

	logic [5:1] vld_s;
	logic [NE-1:0][EW-1:0]        m_s1;
	logic signed [PW-1:0]         p_s2 [NP];
	logic [2:0][EW-1:0]           abc_s2, abc_s3;
	logic signed [PW-1:0]         adj_s3 [NE];
	logic signed [PW-1:0]         adj_s4 [NE];
	logic signed [PW-1:0]         ph_s4 [3];
	logic signed [PW:0]           pl_s4 [3];
	logic signed [DW-1:0]         det_s5;
	logic [NE-1:0][PW-1:0]        mag_s5;
	logic [NE-1:0]                aneg_s5;
	div_t                         nxt, out_q;
	logic                         vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_q <= 1'b0;
		end else begin
			vld_s <= {vld_s[4:1], vld};
			vld_q <= vld_s[5];
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= m;
		abc_s2 <= m_s1[2:0];
		abc_s3 <= abc_s2;
		adj_s4 <= adj_s3;
		out_q <= nxt;
	end

	for (genvar i = 0; i < NP; i++) begin : g_prod
		always_ff @(posedge clk) begin
			p_s2[i] <= $signed(m_s1[PX[i]]) * $signed(m_s1[PY[i]]);
		end
	end

	for (genvar j = 0; j < NE; j++) begin : g_adj
		always_ff @(posedge clk) begin
			adj_s3[j] <= p_s2[2*j] - p_s2[2*j+1];
			mag_s5[j] <= adj_s4[j][PW-1] ? PW'(-adj_s4[j]) : PW'(adj_s4[j]);
			aneg_s5[j] <= adj_s4[j][PW-1];
		end
	end

	// det = a*adj0 + b*adj3 + c*adj6, each split at bit 32 of the cofactor
	for (genvar t = 0; t < 3; t++) begin : g_det
		always_ff @(posedge clk) begin
			ph_s4[t] <= $signed(abc_s3[t]) * $signed(adj_s3[3*t][PW-1:EW]);
			pl_s4[t] <= $signed(abc_s3[t]) * $signed({1'b0, adj_s3[3*t][EW-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		det_s5 <= ((DW'(ph_s4[0]) + DW'(ph_s4[1]) + DW'(ph_s4[2])) <<< EW)
			+ DW'(pl_s4[0]) + DW'(pl_s4[1]) + DW'(pl_s4[2]);
	end

	always_comb begin
		logic          dneg;
		logic [DW-1:0] dmag;
		dneg = det_s5[DW-1];
		dmag = dneg ? DW'(-det_s5) : DW'(det_s5);
		nxt.vld  = 1'b1;
		nxt.sing = (det_s5 == '0);
		nxt.d    = dmag;
		for (int j = 0; j < NE; j++) begin
			nxt.r[j]   = DW'(mag_s5[j] >> 1);
			nxt.nb[j]  = mag_s5[j][0];
			nxt.q[j]   = '0;
			nxt.neg[j] = aneg_s5[j] ^ dneg;
			nxt.ovf[j] = {{(DW+1-PW){1'b0}}, mag_s5[j]} >= {dmag, 1'b0};
		end
	end

	always_comb begin
		dout = out_q;
		dout.vld = vld_q;
	end
endmodule

// File: rtl/m3i_cell.sv
`timescale 1ns / 1ps
module m3i_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  m3i_pkg::div_t din,
	output m3i_pkg::div_t dout
);
	import m3i_pkg::*;

	div_t nxt, data_q;
	logic vld_q;

	always_comb begin
		logic [DW-1:0] rs;
		nxt = din;
		nxt.nb = '0;
		for (int j = 0; j < NE; j++) begin
			rs = {din.r[j][DW-2:0], din.nb[j]};
			if (rs >= din.d) begin
				nxt.r[j] = rs - din.d;
				nxt.q[j] = {din.q[j][QW-2:0], 1'b1};
			end else begin
				nxt.r[j] = rs;
				nxt.q[j] = {din.q[j][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		dout = data_q;
		dout.vld = vld_q;
	end
endmodule

// File: rtl/matrix3_inverse.sv
`timescale 1ns / 1ps
// channel   signals                         beat taken when
// input     start, busy, m00..m22           start && !busy
// result    done, r00..r22, singular, saturated   done
//
// One matrix per cycle; busy stays low.
// Pipeline: 5 stages of products and determinant, one setup stage,
// 33 division cells (one quotient bit each, nine lanes), one output register.
// arst_n clears the valid chain only; no result is lost to a stall since the
// receiver cannot hold results off.
module matrix3_inverse (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic        done,
	output logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
	output logic        singular,
	output logic        saturated
);
	import m3i_pkg::*;

	logic [NE-1:0][EW-1:0] m_in;
	div_t                  chain [QW+1];
	logic [NE-1:0][EW-1:0] r_q;
	logic                  done_q, sing_q, sat_q;
	logic [NE-1:0][EW-1:0] r_nxt;
	logic                  sat_nxt;

	assign busy = 1'b0;
	assign m_in = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

	m3i_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start),
		.m      (m_in),
		.dout   (chain[0])
	);

	for (genvar i = 0; i < QW; i++) begin : g_cell
		m3i_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	always_comb begin
		div_t fin;
		fin = chain[QW];
		sat_nxt = 1'b0;
		for (int j = 0; j < NE; j++) begin
			if (fin.neg[j]) begin
				if (fin.ovf[j] || fin.q[j] > QNEG_MAX) begin
					r_nxt[j] = 32'h80000000;
					sat_nxt = 1'b1;
				end else begin
					r_nxt[j] = EW'(-fin.q[j]);
				end
			end else begin
				if (fin.ovf[j] || fin.q[j] > QPOS_MAX) begin
					r_nxt[j] = 32'h7FFFFFFF;
					sat_nxt = 1'b1;
				end else begin
					r_nxt[j] = fin.q[j][EW-1:0];
				end
			end
		end
		if (fin.sing) begin
			r_nxt = '0;
			sat_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[QW].vld;
		end
	end

	always_ff @(posedge clk) begin
		r_q    <= r_nxt;
		sing_q <= chain[QW].sing;
		sat_q  <= sat_nxt;
	end

	assign done      = done_q;
	assign singular  = sing_q;
	assign saturated = sat_q;
	assign r00 = r_q[0];
	assign r01 = r_q[1];
	assign r02 = r_q[2];
	assign r10 = r_q[3];
	assign r11 = r_q[4];
	assign r12 = r_q[5];
	assign r20 = r_q[6];
	assign r21 = r_q[7];
	assign r22 = r_q[8];
endmodule

// File: rtl/m3i_checker.sv
`timescale 1ns / 1ps
`include "matrix3_inverse_macros.svh"
module m3i_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        singular,
	input logic        saturated,
	input logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22
);
	`M3I_NEVER(a_busy_low, busy)
	`M3I_IMPLY(a_latency, done, $past(start, 40))
	`M3I_IMPLY(a_sing_zero, done && singular, (r00 | r01 | r02 | r10 | r11 | r12 | r20 | r21 | r22) == 32'h0)
	`M3I_NEVER(a_sing_nosat, done && singular && saturated)
endmodule

bind matrix3_inverse m3i_checker u_chk (.*);
